/* src/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

   // Operation codes carried on req_op
   localparam logic [2:0] OP_INSERT   = 3'd0;
   localparam logic [2:0] OP_DELETE   = 3'd1;
   localparam logic [2:0] OP_RETRIEVE = 3'd2;
   localparam logic [2:0] OP_REPLACE  = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   // Status codes returned on rsp_status
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Fixed port widths
   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } seq_state_type;

endpackage

/* src/positional_list_engine_top.sv */
`timescale 1ns / 1ps

// Positional list engine: an ordered list of up to CAPACITY entries held in
// one single-port-write, registered-read memory, addressed by position.
// Request channel (req_valid / req_stall): op, position and value of one
// word. Insert, delete, retrieve, replace and clear are supported.
// Response channel (rsp_valid / rsp_stall): status, read value, entry count
// and empty flag, one word per request.
// Insert moves every entry at or above the target position up by one slot
// and delete every entry above it down by one, one entry per cycle through
// the memory's single read and write port. At most one request is in
// progress at a time.
// The response sits in an output register: a stalled response holds its
// value while the next request is already accepted and worked on; the
// finished result then waits in the sequencer until the register frees.
// Reset empties the list (count zero) and clears both channels. Memory
// contents are not cleared; entries are only read below the count.
module positional_list_engine_top #(
   parameter int CAPACITY    = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ple_pkg::OP_W-1:0]       req_op,
   input  logic [ple_pkg::POS_W-1:0]      req_position,
   input  logic [ple_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ple_pkg::STAT_W-1:0]     rsp_status,
   output logic [ple_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [ple_pkg::COUNT_W-1:0]    rsp_count,
   output logic                           rsp_is_empty
);

   import ple_pkg::*;

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // Entry store
   logic [ENTRY_WIDTH-1:0] store_mem [CAPACITY];
   logic [ENTRY_WIDTH-1:0] mem_q_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [ENTRY_WIDTH-1:0] mem_wdata;

   // Sequencer and item registers
   seq_state_type          state_ff, state_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [ENTRY_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]          n_reads_ff, n_reads_in;
   logic [AW-1:0]          rd_addr_ff, rd_addr_in;
   logic [AW-1:0]          prev_addr_ff, prev_addr_in;
   logic                   rd_pending_ff, rd_pending_in;
   logic                   dir_up_ff, dir_up_in;
   logic                   capture_ff, capture_in;
   logic                   final_we_ff, final_we_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [VALUE_W-1:0]     rd_ff, rd_in;
   logic [CW-1:0]          count_ff, count_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]     rsp_read_ff, rsp_read_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   req_accept;
   logic                   rsp_load;
   logic [CMPW-1:0]        pos_ext;
   logic [CMPW-1:0]        cnt_ext;
   logic [CMPW-1:0]        cap_ext;
   logic [CW-1:0]          pos_cw;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign pos_ext = CMPW'(req_position);
   assign cnt_ext = CMPW'(count_ff);
   assign cap_ext = CMPW'(CAPACITY);
   assign pos_cw  = CW'(req_position);

   // Decode the request, step the shift and drain the result
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      n_reads_in    = n_reads_ff;
      rd_addr_in    = rd_addr_ff;
      prev_addr_in  = prev_addr_ff;
      rd_pending_in = 1'b0;
      dir_up_in     = dir_up_ff;
      capture_in    = capture_ff;
      final_we_in   = final_we_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = val_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in    = ST_SCAN;
               pos_in      = AW'(req_position);
               val_in      = ENTRY_WIDTH'(req_value);
               n_reads_in  = '0;
               rd_addr_in  = AW'(req_position);
               dir_up_in   = 1'b1;
               capture_in  = 1'b0;
               final_we_in = 1'b0;
               status_in   = STAT_DONE;
               rd_in       = '0;
               case (req_op)
                  OP_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        status_in = STAT_RANGE;
                     end else if (cnt_ext >= cap_ext) begin
                        status_in = STAT_FULL;
                     end else begin
                        // move entries count-1 .. position up by one
                        n_reads_in  = count_ff - pos_cw;
                        rd_addr_in  = AW'(count_ff - CW'(1));
                        dir_up_in   = 1'b0;
                        final_we_in = 1'b1;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  OP_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = STAT_RANGE;
                     end else begin
                        // read the victim, then pull later entries down
                        n_reads_in = count_ff - pos_cw;
                        capture_in = 1'b1;
                        count_in   = count_ff - CW'(1);
                     end
                  end
                  OP_RETRIEVE: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = STAT_RANGE;
                     end else begin
                        n_reads_in = CW'(1);
                        capture_in = 1'b1;
                     end
                  end
                  OP_REPLACE: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = STAT_RANGE;
                     end else begin
                        final_we_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue the next read
            if (n_reads_ff != '0) begin
               rd_addr_in    = dir_up_ff ? rd_addr_ff + AW'(1) : rd_addr_ff - AW'(1);
               prev_addr_in  = rd_addr_ff;
               n_reads_in    = n_reads_ff - CW'(1);
               rd_pending_in = 1'b1;
            end
            // consume the word read last cycle
            if (rd_pending_ff) begin
               if (capture_ff) begin
                  rd_in      = VALUE_W'(mem_q_ff);
                  capture_in = 1'b0;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = dir_up_ff ? prev_addr_ff - AW'(1) : prev_addr_ff + AW'(1);
                  mem_wdata = mem_q_ff;
               end
            end
            // shift finished: place the new entry
            if ((n_reads_ff == '0) && !rd_pending_ff) begin
               if (final_we_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff;
                  mem_wdata = val_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load or drop the response word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_read_in   = rd_ff;
         rsp_count_in  = COUNT_W'(count_ff);
         rsp_empty_in  = (count_ff == '0);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Entry store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= store_mem[rd_addr_ff];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_pending_ff <= 1'b0;
         n_reads_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_pending_ff <= rd_pending_in;
         n_reads_ff    <= n_reads_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rd_addr_ff    <= rd_addr_in;
      prev_addr_ff  <= prev_addr_in;
      dir_up_ff     <= dir_up_in;
      capture_ff    <= capture_in;
      final_we_ff   <= final_we_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SCAN))
      else $error("store written outside the shift sequence");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a sequence");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (state_in == ST_DONE)) |->
         (!rd_pending_ff && (n_reads_ff == '0)))
      else $error("sequence finished with reads outstanding");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ple_pkg::*;

   localparam int LIST_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_WAIT  = 100;
   localparam int HOLD_LENGTH = 300;

   // op codes the block ignores
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } list_result_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op         = OP_CLEAR;
   logic [POS_W-1:0]     req_position   = '0;
   logic [VALUE_W-1:0]   req_value      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [VALUE_W-1:0]   rsp_read_value;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 rsp_is_empty;

   // shadow copy of the list
   logic [VALUE_W-1:0]   shadow_entries [0:LIST_DEPTH-1];
   int                   shadow_count = 0;

   list_result_type      pending_results [$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   req_idle_on = 1'b1;
   bit                   rsp_idle_on = 1'b1;
   int                   hold_cycles = 0;

   positional_list_engine_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one operation to the shadow list and return the response it yields
   function automatic list_result_type apply_list_op(input logic [OP_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VALUE_W-1:0] val);
      list_result_type res;
      int slot;
      res.status     = STAT_DONE;
      res.read_value = '0;
      case (op)
         OP_INSERT: begin
            if (pos > shadow_count) begin
               res.status = STAT_RANGE;
            end else if (shadow_count >= LIST_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (slot = shadow_count; slot > pos; slot--)
                  shadow_entries[slot] = shadow_entries[slot-1];
               shadow_entries[pos] = val;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (pos >= shadow_count) begin
               res.status = STAT_RANGE;
            end else begin
               res.read_value = shadow_entries[pos];
               for (slot = pos; slot + 1 < shadow_count; slot++)
                  shadow_entries[slot] = shadow_entries[slot+1];
               shadow_count--;
            end
         end
         OP_RETRIEVE: begin
            if (pos >= shadow_count)
               res.status = STAT_RANGE;
            else
               res.read_value = shadow_entries[pos];
         end
         OP_REPLACE: begin
            if (pos >= shadow_count)
               res.status = STAT_RANGE;
            else
               shadow_entries[pos] = val;
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      res.count    = shadow_count[COUNT_W-1:0];
      res.is_empty = (shadow_count == 0);
      return res;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_idle_length();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 10);
   endfunction

   // Offer one word, hold it until taken, then record its expected response
   task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
      int gap;
      gap = req_idle_on ? pick_idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_list_op(op, pos, val));
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 5)
         return '0;
      else if (roll < 10)
         return '1;
      else
         return $urandom;
   endfunction

   // Drive the response stall: random runs, quiet stretches, or a long hold
   initial begin : stall_driver
      int  stall_len;
      bit  stall_value;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            stall_value = 1'b1;
            stall_len   = hold_cycles;
            hold_cycles = 0;
         end else if (!rsp_idle_on) begin
            stall_value = 1'b0;
            stall_len   = 1;
         end else if ($urandom_range(99, 0) < 60) begin
            stall_value = 1'b0;
            stall_len   = $urandom_range(8, 1);
         end else begin
            stall_value = 1'b1;
            stall_len   = pick_idle_length() + 1;
         end
         rsp_stall <= stall_value;
         repeat (stall_len - 1) @(posedge clock);
      end
   end

   function automatic void compare_field(input string field_name,
                                         input logic [VALUE_W-1:0] want,
                                         input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field_name, want, got);
         error_count++;
      end
   endfunction

   // Check each response word against the oldest expectation
   always @(posedge clock) begin : response_checker
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: response with none expected, expected nothing, actual status %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", VALUE_W'(want.status), VALUE_W'(rsp_status));
            compare_field("read_value", want.read_value, rsp_read_value);
            compare_field("count", VALUE_W'(want.count), VALUE_W'(rsp_count));
            compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(rsp_is_empty));
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Operations on an empty list right after reset
   task automatic test_empty_list();
      send_word(OP_RETRIEVE, 7'd0, '0);
      send_word(OP_DELETE, 7'd0, '0);
      send_word(OP_REPLACE, 7'd0, 32'h1234_5678);
      send_word(OP_CLEAR, 7'd0, '0);
      send_word(OP_INSERT, 7'd1, 32'hDEAD_BEEF);
   endtask

   // Every operation at the ends of the list and of the fields
   task automatic test_directed_ops();
      send_word(OP_INSERT, 7'd0, 32'h0000_0000);
      send_word(OP_INSERT, 7'd1, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 7'd1, 32'hA5A5_A5A5);
      send_word(OP_INSERT, 7'd0, 32'h5A5A_5A5A);
      for (int p = 0; p < 4; p++)
         send_word(OP_RETRIEVE, p[POS_W-1:0], '0);
      send_word(OP_REPLACE, 7'd2, 32'h0000_FFFF);
      send_word(OP_REPLACE, 7'd4, 32'hFFFF_0000);
      send_word(OP_RETRIEVE, 7'd2, '0);
      send_word(OP_RETRIEVE, 7'd127, '0);
      send_word(OP_DELETE, 7'd3, '0);
      send_word(OP_DELETE, 7'd0, '0);
      send_word(OP_DELETE, 7'd2, '0);
      send_word(OP_DELETE, 7'd0, '0);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_word(op[OP_W-1:0], 7'd127, 32'hFFFF_FFFF);
      send_word(OP_CLEAR, 7'd0, '0);
      send_word(OP_RETRIEVE, 7'd0, '0);
   endtask

   // Fill to capacity, then probe the full and range checks at the top
   task automatic test_full_list();
      while (shadow_count < LIST_DEPTH)
         send_word(OP_INSERT, POS_W'($urandom_range(shadow_count, 0)), pick_value());
      send_word(OP_INSERT, 7'd64, pick_value());
      send_word(OP_INSERT, POS_W'($urandom_range(LIST_DEPTH - 1, 0)), pick_value());
      send_word(OP_INSERT, 7'd65, pick_value());
      send_word(OP_INSERT, 7'd127, pick_value());
      send_word(OP_RETRIEVE, 7'd63, '0);
      send_word(OP_RETRIEVE, 7'd64, '0);
      send_word(OP_REPLACE, 7'd63, 32'hFFFF_FFFF);
      send_word(OP_DELETE, 7'd0, '0);
      send_word(OP_DELETE, 7'd62, '0);
      send_word(OP_DELETE, 7'd62, '0);
   endtask

   // Hold off the response side while words keep coming, so the input stalls
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      hold_cycles = HOLD_LENGTH;
      for (int n = 0; n < 16; n++)
         send_word(n[0] ? OP_RETRIEVE : OP_INSERT,
                   POS_W'($urandom_range(shadow_count, 0)), pick_value());
      req_idle_on = 1'b1;
   endtask

   // Random mix steered to grow and shrink the list across its whole range
   task automatic test_random_mix(input int num_words);
      int              grow_bias;
      int              roll;
      logic [OP_W-1:0] op;
      int              pos;
      grow_bias = 50;
      for (int n = 0; n < num_words; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(2, 0))
               0:       grow_bias = 85;
               1:       grow_bias = 50;
               default: grow_bias = 15;
            endcase
            req_idle_on = ($urandom_range(3, 0) != 0);
            rsp_idle_on = ($urandom_range(3, 0) != 0);
         end
         roll = $urandom_range(99, 0);
         if (roll < 1)
            op = OP_CLEAR;
         else if (roll < 2)
            op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
         else if (roll < 22)
            op = OP_RETRIEVE;
         else if (roll < 37)
            op = OP_REPLACE;
         else
            op = ($urandom_range(99, 0) < grow_bias) ? OP_INSERT : OP_DELETE;
         // mostly legal positions, some at the boundary, a few anywhere
         roll = $urandom_range(99, 0);
         if (roll < 88) begin
            if (op == OP_INSERT)
               pos = $urandom_range(shadow_count, 0);
            else
               pos = (shadow_count > 0) ? $urandom_range(shadow_count - 1, 0) : 0;
         end else if (roll < 96) begin
            pos = shadow_count + $urandom_range(2, 0);
         end else begin
            pos = $urandom_range(127, 0);
         end
         send_word(op, pos[POS_W-1:0], pick_value());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_directed_ops();
      test_full_list();
      test_backpressure();
      test_random_mix(1700);
      req_valid <= 1'b0;
      // wait for outstanding responses, then for any stray word
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
